// ===== src/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// shared types, sizes and the edge set-up function of the polygon crossing test
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int MAX_VERTICES = 16;
   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int CNT_W        = 5;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // counters stop at the smaller of the vertex bound and the field maximum
   localparam logic [CNT_W-1:0] COUNT_SAT =
      CNT_W'((MAX_VERTICES < 31) ? MAX_VERTICES : 31);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic [CNT_W-1:0]              cnt_type;

   // one edge, already reduced to the four differences of the cross-multiply
   typedef struct packed {
      logic     hit;    // edge straddles the query row
      diff_type a;      // qy - iy
      diff_type b;      // ix - jx
      diff_type c;      // qx - ix
      diff_type dy;     // iy - jy
   } edge_type;

   // one queue entry per accepted vertex beat
   typedef struct packed {
      edge_type e_new;    // previous vertex to this vertex
      edge_type e_close;  // this vertex back to the first one
      logic     start;    // first vertex of a polygon, counters restart
      logic     last;     // closing vertex, a result follows
   } item_type;

   // queue to back end handshake
   typedef struct packed {
      logic     valid;
      item_type item;
   } qout_type;

   function automatic edge_type make_edge(input coord_type ix, input coord_type iy,
                                          input coord_type jx, input coord_type jy,
                                          input coord_type qx, input coord_type qy,
                                          input logic en);
      edge_type e;
      logic     straddle;
      straddle = ((iy < qy) && (jy >= qy)) || ((jy < qy) && (iy >= qy));
      e.hit = en & straddle;
      e.a   = diff_type'(qy) - diff_type'(iy);
      e.b   = diff_type'(ix) - diff_type'(jx);
      e.c   = diff_type'(qx) - diff_type'(ix);
      e.dy  = diff_type'(iy) - diff_type'(jy);
      return e;
   endfunction

endpackage

// ===== src/pip_if.sv =====
// ----------------------------------------------------------------------------
// pip_if
// valid/ready channels for vertex beats and result beats
// ----------------------------------------------------------------------------
interface pip_req_if import pip_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type vertex_x;
   coord_type vertex_y;
   coord_type query_x;
   coord_type query_y;
   logic      last_vertex;

   modport source (output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                   input ready);
   modport sink   (input valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                   output ready);
endinterface

interface pip_rsp_if import pip_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    inside_res;
   cnt_type left_crossings;
   cnt_type right_crossings;

   modport source (output valid, inside_res, left_crossings, right_crossings,
                   input ready);
   modport sink   (input valid, inside_res, left_crossings, right_crossings,
                   output ready);
endinterface

// ===== src/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front
// takes vertex beats, tracks first/previous vertex and query, forms edge records
// ----------------------------------------------------------------------------
module pip_front import pip_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   pip_req_if.sink  req_ch,
   input  logic     q_full,
   output logic     push,
   output item_type push_item
);

   coord_type first_vx_ff, first_vy_ff, prev_vx_ff, prev_vy_ff;
   coord_type held_qx_ff, held_qy_ff;
   logic      mid_ff;

   logic      start;
   coord_type qx, qy, fx, fy;

   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;

   always_comb begin
      start = !mid_ff;
      qx    = start ? req_ch.query_x : held_qx_ff;
      qy    = start ? req_ch.query_y : held_qy_ff;
      fx    = start ? req_ch.vertex_x : first_vx_ff;
      fy    = start ? req_ch.vertex_y : first_vy_ff;
      push_item.e_new   = make_edge(req_ch.vertex_x, req_ch.vertex_y,
                                    prev_vx_ff, prev_vy_ff, qx, qy, mid_ff);
      push_item.e_close = make_edge(fx, fy, req_ch.vertex_x, req_ch.vertex_y,
                                    qx, qy, req_ch.last_vertex);
      push_item.start   = start;
      push_item.last    = req_ch.last_vertex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff      <= 1'b0;
         first_vx_ff <= '0;
         first_vy_ff <= '0;
         prev_vx_ff  <= '0;
         prev_vy_ff  <= '0;
         held_qx_ff  <= '0;
         held_qy_ff  <= '0;
      end else if (push) begin
         if (start) begin
            held_qx_ff  <= req_ch.query_x;
            held_qy_ff  <= req_ch.query_y;
            first_vx_ff <= req_ch.vertex_x;
            first_vy_ff <= req_ch.vertex_y;
         end
         prev_vx_ff <= req_ch.vertex_x;
         prev_vy_ff <= req_ch.vertex_y;
         mid_ff     <= !req_ch.last_vertex;
      end
   end

endmodule

// ===== src/pip_queue.sv =====
// ----------------------------------------------------------------------------
// pip_queue
// short flop queue of edge records between front and back end
// ----------------------------------------------------------------------------
module pip_queue import pip_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output qout_type head
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_pop;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.item  = slot_ff[rd_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

   // occupancy bound and pointer bookkeeping
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !do_pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("push lost");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      QPTR_W'(wr_ff - rd_ff) == QPTR_W'(cnt_ff)) else $error("queue pointers drift");

endmodule

// ===== src/pip_back.sv =====
// ----------------------------------------------------------------------------
// pip_back
// cross-multiplies edges, classifies crossings, keeps counters, drives results
// ----------------------------------------------------------------------------
module pip_back import pip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qout_type  head,
   output logic      pop,
   pip_rsp_if.source rsp_ch
);

   // product stage
   logic     mul_valid_ff;
   prod_type lhs1_ff, rhs1_ff, lhs2_ff, rhs2_ff;
   logic     pos1_ff, pos2_ff, hit1_ff, hit2_ff, start_ff, last_ff;

   // counters and result register
   cnt_type  left_ff, right_ff, left_in, right_in;
   logic     rsp_valid_ff;
   logic     rsp_inside_ff;
   cnt_type  rsp_left_ff, rsp_right_ff;

   logic       adv;
   logic       left1, left2;
   logic [1:0] inc_l, inc_r;
   cnt_type    base_l, base_r;

   function automatic cnt_type sat_add(input cnt_type base, input logic [1:0] inc);
      logic [CNT_W:0] s;
      s = {1'b0, base} + (CNT_W + 1)'(inc);
      return (s > (CNT_W + 1)'(COUNT_SAT)) ? COUNT_SAT : s[CNT_W-1:0];
   endfunction

   assign adv = !rsp_valid_ff || rsp_ch.ready;
   assign pop = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= head.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lhs1_ff  <= head.item.e_new.a * head.item.e_new.b;
         rhs1_ff  <= head.item.e_new.c * head.item.e_new.dy;
         lhs2_ff  <= head.item.e_close.a * head.item.e_close.b;
         rhs2_ff  <= head.item.e_close.c * head.item.e_close.dy;
         pos1_ff  <= head.item.e_new.dy > 0;
         pos2_ff  <= head.item.e_close.dy > 0;
         hit1_ff  <= head.item.e_new.hit;
         hit2_ff  <= head.item.e_close.hit;
         start_ff <= head.item.start;
         last_ff  <= head.item.last;
      end
   end

   always_comb begin
      left1    = pos1_ff ? (lhs1_ff < rhs1_ff) : (lhs1_ff > rhs1_ff);
      left2    = pos2_ff ? (lhs2_ff < rhs2_ff) : (lhs2_ff > rhs2_ff);
      inc_l    = 2'(hit1_ff && left1) + 2'(hit2_ff && left2);
      inc_r    = 2'(hit1_ff && !left1) + 2'(hit2_ff && !left2);
      base_l   = start_ff ? '0 : left_ff;
      base_r   = start_ff ? '0 : right_ff;
      left_in  = sat_add(base_l, inc_l);
      right_in = sat_add(base_r, inc_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mul_valid_ff && last_ff;
         if (mul_valid_ff) begin
            left_ff  <= left_in;
            right_ff <= right_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && mul_valid_ff && last_ff) begin
         rsp_inside_ff <= left_in[0];
         rsp_left_ff   <= left_in;
         rsp_right_ff  <= right_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.inside_res      = rsp_inside_ff;
   assign rsp_ch.left_crossings  = rsp_left_ff;
   assign rsp_ch.right_crossings = rsp_right_ff;

   // counters never pass the saturation limit, results come only from closing vertices
   a_left_sat: assert property (@(posedge clock) disable iff (reset)
      left_ff <= COUNT_SAT && right_ff <= COUNT_SAT) else $error("counter past limit");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(mul_valid_ff && last_ff)) else $error("stray result");
   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_inside_ff == rsp_left_ff[0]) else $error("parity mismatch");

endmodule

// ===== src/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// crossing number test of a query point against a polygon streamed by vertex
// ----------------------------------------------------------------------------
// result path: closing vertex beat passes the queue slot, product and result registers
// throughput: one vertex beat per cycle while the queue is not full, set by the edge
//   records that the front end writes to a 4-entry queue and the back end's two-stage multiply/count path
// reset: synchronous, clears polygon tracking, counters, queue and result valid
// ----------------------------------------------------------------------------
module point_in_polygon_test import pip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pip_req_if.sink   req_ch,
   pip_rsp_if.source rsp_ch
);

   // front end to queue
   logic     push;
   item_type push_item;
   logic     q_full;

   // queue to back end
   qout_type head;
   logic     pop;

   // front end: latches query on a polygon's first vertex, keeps first and
   // previous vertex, and turns each beat into a queue entry with edge records
   // for the new edge and, on a closing vertex, the edge back to the first one
   pip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   // queue decouples vertex intake from result back-pressure
   pip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .head      (head)
   );

   // back end: exact left/right test by cross-multiplication with the sense
   // flipped for falling edges, saturating counters, registered result beat
   pip_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
